// ===== src/echo_escape_expander_macros.svh =====
// ----------------------------------------------------------------------------
// echo_escape_expander_macros.svh
// Assertion macros used by the escape expander RTL.
// ----------------------------------------------------------------------------
`ifndef ECHO_ESCAPE_EXPANDER_MACROS_SVH
`define ECHO_ESCAPE_EXPANDER_MACROS_SVH

// Checked on every rising edge of clk, off while arst_n is low.
`define EEE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define EEE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/eee_pkg.sv =====
// ----------------------------------------------------------------------------
// eee_pkg
// Types, character codes and helper functions of the escape expander.
// ----------------------------------------------------------------------------
`default_nettype none

package eee_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int VALUE_W     = 9;

	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_X      = 8'h78;
	localparam logic [7:0] CHAR_0      = 8'h30;
	localparam logic [7:0] CHAR_1      = 8'h31;
	localparam logic [7:0] CHAR_7      = 8'h37;
	localparam logic [7:0] ESC_BYTE    = 8'h1B;

	localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;
	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_BSLASH,
		ESC_HEX,
		ESC_OCT
	} esc_mode_t;

	typedef struct packed {
		esc_mode_t            mode;
		logic [VALUE_W-1:0]   value;
		logic [1:0]           seen;
		logic [1:0]           allowed;
	} esc_state_t;

	localparam esc_state_t ESC_CLEAR = '{
		mode:    ESC_IDLE,
		value:   '0,
		seen:    2'd0,
		allowed: 2'd0
	};

	// Results of one input item, in order, slot 0 first.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] data;
		logic [MAX_RESULTS-1:0]      kind;
		logic [RES_CNT_W-1:0]        cnt;
	} res_set_t;

	// Append one result; drop it once all slots are taken.
	function automatic res_set_t res_put(res_set_t rs, logic [7:0] b, logic k);
		res_set_t r;
		r = rs;
		if (r.cnt < RES_CNT_W'(MAX_RESULTS)) begin
			r.data[r.cnt[RES_IDX_W-1:0]] = b;
			r.kind[r.cnt[RES_IDX_W-1:0]] = k;
			r.cnt = r.cnt + RES_CNT_W'(1);
		end
		return r;
	endfunction

	// Close a numeric escape: zero value ends the unit, else emit the low byte.
	function automatic res_set_t res_complete(res_set_t rs, logic [VALUE_W-1:0] v);
		res_set_t r;
		if (v == '0) begin
			r = res_put(rs, 8'h00, KIND_END);
		end else begin
			r = res_put(rs, v[7:0], KIND_DATA);
		end
		return r;
	endfunction

	// Control byte of a letter escape, zero when the letter has none.
	function automatic logic [7:0] letter_code(logic [7:0] c);
		logic [7:0] code;
		unique case (c)
			"n":     code = 8'h0A;
			"t":     code = 8'h09;
			"f":     code = 8'h0C;
			"a":     code = 8'h07;
			"b":     code = 8'h08;
			"e":     code = ESC_BYTE;
			"r":     code = 8'h0D;
			"v":     code = 8'h0B;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	function automatic logic is_hex_digit(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(logic [7:0] c);
		logic [7:0] d;
		if (c >= "0" && c <= "9") begin
			d = c - 8'h30;
		end else if (c >= "a" && c <= "f") begin
			d = c - 8'h57;
		end else begin
			d = c - 8'h37;
		end
		return d[3:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/eee_decode.sv =====
// ----------------------------------------------------------------------------
// eee_decode
// Next escape state and result set for one registered input item.
// ----------------------------------------------------------------------------
`default_nettype none

module eee_decode (
	input  wire eee_pkg::esc_state_t st_cur,
	input  wire logic [7:0]          in_byte,
	input  wire logic                byte_present,
	input  wire logic                end_of_text,
	output eee_pkg::esc_state_t      st_next,
	output eee_pkg::res_set_t        res
);

	eee_pkg::esc_state_t              st;
	eee_pkg::res_set_t                rs;
	logic                             go_idle;
	logic [7:0]                       code;
	logic [eee_pkg::VALUE_W-1:0]      value_n;
	logic [1:0]                       seen_n;
	logic                             is_oct;

	always_comb begin
		st      = st_cur;
		rs      = '0;
		go_idle = 1'b0;
		code    = eee_pkg::letter_code(in_byte);
		is_oct  = (in_byte >= eee_pkg::CHAR_0) && (in_byte <= eee_pkg::CHAR_7);
		seen_n  = st_cur.seen + 2'd1;
		value_n = '0;

		if (byte_present) begin
			unique case (st_cur.mode)
				eee_pkg::ESC_IDLE: begin
					go_idle = 1'b1;
				end
				eee_pkg::ESC_BSLASH: begin
					st = eee_pkg::ESC_CLEAR;
					if (code != 8'h00) begin
						rs = eee_pkg::res_put(rs, code, eee_pkg::KIND_DATA);
					end else if (in_byte == eee_pkg::CHAR_X) begin
						st.mode = eee_pkg::ESC_HEX;
					end else if (in_byte == eee_pkg::CHAR_0) begin
						st.mode    = eee_pkg::ESC_OCT;
						st.allowed = eee_pkg::OCT_MAX_DIGITS;
					end else if (in_byte >= eee_pkg::CHAR_1 && in_byte <= eee_pkg::CHAR_7) begin
						st.mode    = eee_pkg::ESC_OCT;
						st.value   = {{(eee_pkg::VALUE_W-3){1'b0}}, in_byte[2:0]};
						st.seen    = 2'd1;
						st.allowed = eee_pkg::OCT_MAX_DIGITS;
					end else begin
						rs = eee_pkg::res_put(rs, eee_pkg::CHAR_BSLASH, eee_pkg::KIND_DATA);
						rs = eee_pkg::res_put(rs, in_byte, eee_pkg::KIND_DATA);
					end
				end
				eee_pkg::ESC_HEX: begin
					if (eee_pkg::is_hex_digit(in_byte)) begin
						value_n = {st_cur.value[4:0], eee_pkg::hex_nibble(in_byte)};
						if (seen_n >= eee_pkg::HEX_MAX_DIGITS) begin
							rs = eee_pkg::res_complete(rs, value_n);
							st = eee_pkg::ESC_CLEAR;
						end else begin
							st.value = value_n;
							st.seen  = seen_n;
						end
					end else begin
						if (st_cur.seen == 2'd0) begin
							rs = eee_pkg::res_put(rs, eee_pkg::CHAR_BSLASH, eee_pkg::KIND_DATA);
							rs = eee_pkg::res_put(rs, eee_pkg::CHAR_X, eee_pkg::KIND_DATA);
						end else begin
							rs = eee_pkg::res_complete(rs, st_cur.value);
						end
						st      = eee_pkg::ESC_CLEAR;
						go_idle = 1'b1;
					end
				end
				eee_pkg::ESC_OCT: begin
					if (is_oct) begin
						value_n = {st_cur.value[5:0], in_byte[2:0]};
						if (seen_n >= st_cur.allowed) begin
							rs = eee_pkg::res_complete(rs, value_n);
							st = eee_pkg::ESC_CLEAR;
						end else begin
							st.value = value_n;
							st.seen  = seen_n;
						end
					end else begin
						rs      = eee_pkg::res_complete(rs, st_cur.value);
						st      = eee_pkg::ESC_CLEAR;
						go_idle = 1'b1;
					end
				end
				default: begin
					st = eee_pkg::ESC_CLEAR;
				end
			endcase

			if (go_idle) begin
				if (in_byte == eee_pkg::CHAR_BSLASH) begin
					st.mode = eee_pkg::ESC_BSLASH;
				end else begin
					rs = eee_pkg::res_put(rs, in_byte, eee_pkg::KIND_DATA);
				end
			end
		end

		// End of text: flush a pending escape, then close the unit.
		if (end_of_text) begin
			unique case (st.mode)
				eee_pkg::ESC_IDLE: begin
				end
				eee_pkg::ESC_BSLASH: begin
					rs = eee_pkg::res_put(rs, eee_pkg::CHAR_BSLASH, eee_pkg::KIND_DATA);
				end
				eee_pkg::ESC_HEX: begin
					if (st.seen == 2'd0) begin
						rs = eee_pkg::res_put(rs, eee_pkg::CHAR_BSLASH, eee_pkg::KIND_DATA);
						rs = eee_pkg::res_put(rs, eee_pkg::CHAR_X, eee_pkg::KIND_DATA);
					end else begin
						rs = eee_pkg::res_complete(rs, st.value);
					end
				end
				eee_pkg::ESC_OCT: begin
					rs = eee_pkg::res_complete(rs, st.value);
				end
				default: begin
				end
			endcase
			rs = eee_pkg::res_put(rs, 8'h00, eee_pkg::KIND_END);
			st = eee_pkg::ESC_CLEAR;
		end

		st_next = st;
		res     = rs;
	end

endmodule

`default_nettype wire

// ===== src/eee_out_buf.sv =====
// ----------------------------------------------------------------------------
// eee_out_buf
// Result register: holds one item's result set and sends it one transfer
// at a time, tlast on the final one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "echo_escape_expander_macros.svh"

module eee_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire eee_pkg::res_set_t res,
	output logic                   free,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]             m_axis_tuser,   // [0] out_kind
	output logic                   m_axis_tlast    // last_of_run
);

	logic                                        valid_s2;
	logic [eee_pkg::MAX_RESULTS-1:0][7:0]        data_s2;
	logic [eee_pkg::MAX_RESULTS-1:0]             kind_s2;
	logic [eee_pkg::RES_CNT_W-1:0]               cnt_s2;
	logic [eee_pkg::RES_IDX_W-1:0]               idx_q;
	logic                                        last;
	logic                                        xfer;

	assign last = ({1'b0, idx_q} == (cnt_s2 - eee_pkg::RES_CNT_W'(1)));
	assign xfer = valid_s2 && m_axis_tready;
	assign free = !valid_s2 || (xfer && last);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2[idx_q];
	assign m_axis_tuser  = kind_s2[idx_q];
	assign m_axis_tlast  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (xfer) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + eee_pkg::RES_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= res.data;
			kind_s2 <= res.kind;
			cnt_s2  <= res.cnt;
		end
	end

	`EEE_ASSERT(a_load_when_free, load |-> free, "result set loaded over one still in flight")
	`EEE_ASSERT(a_load_nonempty, load |-> (res.cnt != '0), "empty result set loaded")
	`EEE_ASSERT(a_idx_in_range, valid_s2 |-> ({1'b0, idx_q} < cnt_s2), "result index past count")
	`EEE_ASSERT(a_run_continues, (xfer && !last) |=> valid_s2, "run dropped before its last transfer")

endmodule

`default_nettype wire

// ===== src/echo_escape_expander.sv =====
// ----------------------------------------------------------------------------
// echo_escape_expander
// Streaming expander of echo-style backslash escapes: control letters,
// \x hex, octal, zero escapes that end a unit, end-of-text flush.
// ----------------------------------------------------------------------------
//
//   channel   dir  tdata        tuser          tlast
//   s_axis    in   in_byte      byte_present   end_of_text
//   m_axis    out  out_byte     out_kind       last_of_run
//
// Flow: an item waits in the input register, is decoded combinationally
// into zero to four results, and those leave the result register one
// transfer per cycle while m_axis_tready is high.
// An item that gives no result loads nothing and frees the slot.
// Reset: arst_n clears the escape state and both valid flags; no sweep.
// Stalls: m_axis_tready low holds the result register and, once the input
// register is full, drops s_axis_tready in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_escape_expander (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire logic [0:0] s_axis_tuser,   // [0] byte_present
	input  wire logic       s_axis_tlast,   // end_of_text
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]      m_axis_tuser,   // [0] out_kind
	output logic            m_axis_tlast    // last_of_run
);

	// Input register
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                present_s1;
	logic                eot_s1;

	// Escape state carried from item to item
	eee_pkg::esc_state_t state_q;
	eee_pkg::esc_state_t state_next;
	eee_pkg::res_set_t   res;

	logic free;
	logic consume;
	logic load;

	// Advance the input item once the result register can take its set.
	assign consume       = valid_s1 && free;
	assign load          = consume && (res.cnt != '0);
	assign s_axis_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload of the input register: hold while stalled.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1    <= s_axis_tdata;
			present_s1 <= s_axis_tuser[0];
			eot_s1     <= s_axis_tlast;
		end
	end

	// Commit the escape state only when the item actually moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eee_pkg::ESC_CLEAR;
		end else if (consume) begin
			state_q <= state_next;
		end
	end

	eee_decode u_decode (
		.st_cur       (state_q),
		.in_byte      (byte_s1),
		.byte_present (present_s1),
		.end_of_text  (eot_s1),
		.st_next      (state_next),
		.res          (res)
	);

	eee_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.res           (res),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
